// ----- sv/hrte_pkg.sv -----
package hrte_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    // wide enough for both the counter and the saturation limit of the output
    localparam int SAT_W = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [2:0] CMD_CLEAR     = 3'd0;
    localparam logic [2:0] CMD_INSERT    = 3'd1;
    localparam logic [2:0] CMD_LOOKUP    = 3'd2;
    localparam logic [2:0] CMD_LOOKUP_IN = 3'd3;
    localparam logic [2:0] CMD_CANDIDATE = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_TYPE  = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    localparam logic [1:0] TYPE_INPUT   = 2'd1;
    localparam logic [1:0] TYPE_FEATURE = 2'd3;

    typedef struct packed {
        logic [1:0]  rtype;
        logic [7:0]  id;
        logic [7:0]  inst;
        logic [15:0] handle;
        logic        notify;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

endpackage

// ----- sv/hrte_ram.sv -----
module hrte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/hid_report_table_engine_top.sv -----
// HID report table engine. Each accepted command transaction yields exactly one result
// transaction. Clear, insert and unused commands, and lookups and candidate entries on an
// empty table, go from acceptance straight to the result state, which loads the output
// register once it is free. Otherwise lookups and candidate entries read the stored entries
// from the table memory one per cycle through the single read port of that memory, then
// pass a drain state before the result state. A new command is taken only once the
// previous one has been placed in the output register, which may still be waiting for
// m_ready. Table contents need no clearing pass: only entries below the fill count are
// ever read.
module hid_report_table_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_report_type,
    input  logic [7:0]  s_report_id,
    input  logic [7:0]  s_instance_req,
    input  logic [15:0] s_value_handle,
    input  logic        s_has_notify,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_handle,
    output logic [4:0]  m_usable_inputs,
    output logic        m_conflict,
    output logic        m_verdict_ready
);

    import hrte_pkg::*;

    state_t state_reg, state_next;

    // latched command
    logic [2:0]  cmd_reg;
    logic [7:0]  type_reg;
    logic [7:0]  id_reg;
    logic [7:0]  inst_reg;
    logic [15:0] vh_reg;
    logic        notify_reg;
    logic        last_reg;

    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] usable_count_reg;
    logic             table_numbered_reg;
    logic             pair_hit_reg;
    logic             cand_numbered_reg;

    logic [IDX_W-1:0] scan_idx_reg;
    logic             rd_pending_reg;
    logic             found_reg;
    logic [15:0]      found_handle_reg;

    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [15:0]      m_handle_reg;
    logic [4:0]       m_usable_reg;
    logic             m_conflict_reg;
    logic             m_verdict_reg;

    logic   accept;
    logic   out_free;
    logic   is_scan_cmd;
    logic   last_issue;
    logic   ram_re;
    logic   ram_we;
    logic   load_out;
    entry_t ram_rdata;
    entry_t wr_entry;
    logic   hit;

    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign is_scan_cmd = (s_command == CMD_LOOKUP) || (s_command == CMD_LOOKUP_IN) ||
                         (s_command == CMD_CANDIDATE);
    assign last_issue  = (CNT_W'(scan_idx_reg) == entry_count_reg - CNT_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (is_scan_cmd && (entry_count_reg != '0)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_ready  = 1'b0;
        ram_re   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                ram_re = 1'b1;
            end
            ST_DRAIN: begin
                ram_re = 1'b0;
            end
            ST_RESULT: begin
                load_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // compare of the entry read in the previous cycle
    always_comb begin
        hit = (type_reg[7:2] == 6'd0) && (ram_rdata.rtype == type_reg[1:0]) &&
              (ram_rdata.id == id_reg) &&
              ((cmd_reg != CMD_LOOKUP_IN) || (ram_rdata.inst == inst_reg));
    end

    // result and state update
    logic [1:0]       res_status;
    logic [15:0]      res_handle;
    logic             res_conflict;
    logic             res_verdict;
    logic [CNT_W-1:0] entry_count_next;
    logic [CNT_W-1:0] usable_count_next;
    logic             table_numbered_next;
    logic             pair_hit_next;
    logic             cand_numbered_next;
    logic [SAT_W-1:0] usable_ext;
    logic             type_valid;

    assign type_valid = (type_reg[7:2] == 6'd0) && (type_reg[1:0] != 2'd0);

    always_comb begin
        res_status          = STAT_OK;
        res_handle          = 16'd0;
        res_conflict        = 1'b0;
        res_verdict         = 1'b0;
        entry_count_next    = entry_count_reg;
        usable_count_next   = usable_count_reg;
        table_numbered_next = table_numbered_reg;
        pair_hit_next       = pair_hit_reg;
        cand_numbered_next  = cand_numbered_reg;
        ram_we              = 1'b0;
        case (cmd_reg)
            CMD_CLEAR: begin
                entry_count_next    = '0;
                usable_count_next   = '0;
                table_numbered_next = 1'b0;
                pair_hit_next       = 1'b0;
                cand_numbered_next  = 1'b0;
            end
            CMD_INSERT: begin
                if (!type_valid) begin
                    res_status = STAT_BAD_TYPE;
                end else if (entry_count_reg >= CNT_W'(MAX_ENTRIES)) begin
                    res_status = STAT_FULL;
                end else begin
                    ram_we           = load_out;
                    entry_count_next = entry_count_reg + CNT_W'(1);
                    if (id_reg != 8'd0) begin
                        table_numbered_next = 1'b1;
                    end
                    if ((type_reg[1:0] == TYPE_INPUT) && notify_reg) begin
                        usable_count_next = usable_count_reg + CNT_W'(1);
                    end
                end
            end
            CMD_LOOKUP, CMD_LOOKUP_IN: begin
                if (found_reg) begin
                    res_handle = found_handle_reg;
                end else begin
                    res_status = STAT_NOT_FOUND;
                end
            end
            CMD_CANDIDATE: begin
                pair_hit_next      = pair_hit_reg || found_reg;
                cand_numbered_next = cand_numbered_reg || (id_reg != 8'd0);
                if (last_reg) begin
                    res_verdict  = 1'b1;
                    res_conflict = (entry_count_reg != '0) &&
                                   (pair_hit_next ||
                                    (table_numbered_reg != cand_numbered_next));
                    pair_hit_next      = 1'b0;
                    cand_numbered_next = 1'b0;
                end
            end
            default: begin
                res_status = STAT_OK;
            end
        endcase
        usable_ext = SAT_W'(usable_count_next);
    end

    assign wr_entry = '{rtype:  type_reg[1:0],
                        id:     id_reg,
                        inst:   inst_reg,
                        handle: vh_reg,
                        notify: notify_reg};

    hrte_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (entry_count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            entry_count_reg    <= '0;
            usable_count_reg   <= '0;
            table_numbered_reg <= 1'b0;
            pair_hit_reg       <= 1'b0;
            cand_numbered_reg  <= 1'b0;
            rd_pending_reg     <= 1'b0;
            found_reg          <= 1'b0;
            scan_idx_reg       <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_pending_reg <= ram_re;

            if (accept) begin
                found_reg    <= 1'b0;
                scan_idx_reg <= '0;
            end else if (ram_re) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end

            // first match in insertion order wins
            if (rd_pending_reg && hit && !found_reg) begin
                found_reg <= 1'b1;
            end

            if (load_out) begin
                entry_count_reg    <= entry_count_next;
                usable_count_reg   <= usable_count_next;
                table_numbered_reg <= table_numbered_next;
                pair_hit_reg       <= pair_hit_next;
                cand_numbered_reg  <= cand_numbered_next;
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_command;
            type_reg   <= s_report_type;
            id_reg     <= s_report_id;
            inst_reg   <= s_instance_req;
            vh_reg     <= s_value_handle;
            notify_reg <= s_has_notify;
            last_reg   <= s_last;
        end
        if (rd_pending_reg && hit && !found_reg) begin
            found_handle_reg <= ram_rdata.handle;
        end
        if (load_out) begin
            m_status_reg   <= res_status;
            m_handle_reg   <= res_handle;
            m_usable_reg   <= (usable_ext > SAT_W'(31)) ? 5'd31 : usable_ext[4:0];
            m_conflict_reg <= res_conflict;
            m_verdict_reg  <= res_verdict;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_handle        = m_handle_reg;
    assign m_usable_inputs = m_usable_reg;
    assign m_conflict      = m_conflict_reg;
    assign m_verdict_ready = m_verdict_reg;

endmodule
